>>> rtl/mfmt_pkg.sv
// shared constants and types for the multiturn feedback tracker
// no dependencies; used by the channel interfaces and the top level
package mfmt_pkg;

    localparam int COUNTS_PER_TURN = 8192;
    localparam int REV_BITS        = 24;
    localparam int HALF_TURN       = COUNTS_PER_TURN / 2;

    localparam int PAYLOAD_W  = 64;
    localparam int LENGTH_W   = 4;
    localparam int WORD_W     = 16;
    localparam int TIMEOUT_W  = 8;
    localparam int REV_OUT_W  = 24;
    localparam int POSITION_W = 37;

    localparam logic [LENGTH_W-1:0]  FRAME_LENGTH  = LENGTH_W'(8);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(10);

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_TICK  = 1'b1
    } t_opcode;

endpackage

>>> rtl/mfmt_in_if.sv
// request channel into the tracker: one feedback frame or one timer tick
// depends on mfmt_pkg
interface mfmt_in_if;
    logic                                 valid;
    logic                                 ready;
    mfmt_pkg::t_opcode                    opcode;
    logic [mfmt_pkg::PAYLOAD_W-1:0]       frame_payload;
    logic [mfmt_pkg::LENGTH_W-1:0]        frame_length;

    modport source (output valid, opcode, frame_payload, frame_length, input ready);
    modport sink   (input valid, opcode, frame_payload, frame_length, output ready);
endinterface

>>> rtl/mfmt_out_if.sv
// result channel out of the tracker: decoded words, position and link status
// depends on mfmt_pkg
interface mfmt_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  frame_accepted;
    logic        [mfmt_pkg::WORD_W-1:0]    encoder_raw;
    logic signed [mfmt_pkg::WORD_W-1:0]    speed_rpm;
    logic signed [mfmt_pkg::WORD_W-1:0]    current_raw;
    logic        [mfmt_pkg::WORD_W-1:0]    spare_word;
    logic signed [mfmt_pkg::REV_OUT_W-1:0] revolutions;
    logic signed [mfmt_pkg::POSITION_W-1:0] position_count;
    logic                                  link_online;
    logic                                  went_offline;

    modport source (output valid, frame_accepted, encoder_raw, speed_rpm, current_raw,
                    spare_word, revolutions, position_count, link_online, went_offline,
                    input ready);
    modport sink   (input valid, frame_accepted, encoder_raw, speed_rpm, current_raw,
                    spare_word, revolutions, position_count, link_online, went_offline,
                    output ready);
endinterface

>>> rtl/motor_feedback_multiturn_tracker_unit.sv
// Multiturn encoder tracker with link watchdog. Each request is an 8-byte
// feedback frame or a timer tick and yields exactly one result. An accepted
// request waits in the input register while the update logic computes the
// next running state and the result; both are registered together, so the
// result register is written as the request leaves the input register. A new
// request is taken every cycle unless the result side stalls; the running state
// (previous encoder, revolution counter, watchdog, online flag, last frame) is
// updated in a single pass as the request leaves the input register, so
// throughput is one request per clock unless the result side stalls.
// depends on mfmt_pkg, mfmt_in_if, mfmt_out_if
module motor_feedback_multiturn_tracker_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mfmt_pkg::TIMEOUT_W-1:0]      i_cfg_wdata,
    mfmt_in_if.sink                             i_in,
    mfmt_out_if.source                          o_out
);

    // configuration
    logic [mfmt_pkg::TIMEOUT_W-1:0] r_timeout;

    // input register
    logic                             r_s1_valid;
    mfmt_pkg::t_opcode                r_s1_op;
    logic [mfmt_pkg::PAYLOAD_W-1:0]   r_s1_payload;
    logic [mfmt_pkg::LENGTH_W-1:0]    r_s1_len;

    // running state
    logic [mfmt_pkg::WORD_W-1:0]      r_prev_enc;
    logic [mfmt_pkg::REV_BITS-1:0]    r_rev;
    logic [mfmt_pkg::TIMEOUT_W-1:0]   r_wd;
    logic                             r_online;
    logic [mfmt_pkg::PAYLOAD_W-1:0]   r_last;

    logic [mfmt_pkg::WORD_W-1:0]      n_prev_enc;
    logic [mfmt_pkg::REV_BITS-1:0]    n_rev;
    logic [mfmt_pkg::TIMEOUT_W-1:0]   n_wd;
    logic                             n_online;
    logic [mfmt_pkg::PAYLOAD_W-1:0]   n_last;

    // result register
    logic                                    r_out_valid;
    logic                                    r_o_accepted;
    logic                                    r_o_dropped;
    logic signed [mfmt_pkg::REV_OUT_W-1:0]   r_o_rev;
    logic signed [mfmt_pkg::POSITION_W-1:0]  r_o_pos;

    logic n_accepted;
    logic n_dropped;
    logic s1_adv;
    logic frame_ok;

    logic        [mfmt_pkg::WORD_W-1:0]     enc;
    logic signed [mfmt_pkg::WORD_W-1:0]     delta;
    logic signed [31:0]                     rev_ext;
    logic        [mfmt_pkg::POSITION_W-1:0] pos;

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;

    assign frame_ok = (r_s1_op == mfmt_pkg::OP_FRAME) && (r_s1_len == mfmt_pkg::FRAME_LENGTH);
    assign enc      = r_s1_payload[63:48];
    // wrapped 16-bit encoder step
    assign delta    = signed'(enc - r_prev_enc);

    always_comb begin
        n_prev_enc = r_prev_enc;
        n_rev      = r_rev;
        n_wd       = r_wd;
        n_online   = r_online;
        n_last     = r_last;
        n_accepted = 1'b0;
        n_dropped  = 1'b0;
        if (frame_ok) begin
            if (32'(delta) < -32'(mfmt_pkg::HALF_TURN)) begin
                n_rev = r_rev + mfmt_pkg::REV_BITS'(1);
            end else if (32'(delta) > 32'(mfmt_pkg::HALF_TURN)) begin
                n_rev = r_rev - mfmt_pkg::REV_BITS'(1);
            end
            n_prev_enc = enc;
            n_last     = r_s1_payload;
            n_wd       = r_timeout;
            n_online   = 1'b1;
            n_accepted = 1'b1;
        end else if (r_s1_op == mfmt_pkg::OP_TICK && r_online) begin
            if (r_wd <= mfmt_pkg::TIMEOUT_W'(1)) begin
                // watchdog ran out: link goes offline, flagged on this result
                n_wd      = '0;
                n_online  = 1'b0;
                n_dropped = 1'b1;
            end else begin
                n_wd = r_wd - mfmt_pkg::TIMEOUT_W'(1);
            end
        end
    end

    assign rev_ext = 32'(signed'(n_rev));
    assign pos     = mfmt_pkg::POSITION_W'(rev_ext)
                   * mfmt_pkg::POSITION_W'(mfmt_pkg::COUNTS_PER_TURN)
                   + mfmt_pkg::POSITION_W'(n_prev_enc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= mfmt_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_op      <= i_in.opcode;
            r_s1_payload <= i_in.frame_payload;
            r_s1_len     <= i_in.frame_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_enc <= '0;
            r_rev      <= '0;
            r_wd       <= '0;
            r_online   <= 1'b0;
            r_last     <= '0;
        end else if (s1_adv) begin
            r_prev_enc <= n_prev_enc;
            r_rev      <= n_rev;
            r_wd       <= n_wd;
            r_online   <= n_online;
            r_last     <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_accepted <= n_accepted;
            r_o_dropped  <= n_dropped;
            r_o_rev      <= rev_ext[mfmt_pkg::REV_OUT_W-1:0];
            r_o_pos      <= signed'(pos);
        end
    end

    // decoded words and link flag follow the state, which only moves with the result register
    assign o_out.valid          = r_out_valid;
    assign o_out.frame_accepted = r_o_accepted;
    assign o_out.encoder_raw    = r_last[63:48];
    assign o_out.speed_rpm      = signed'(r_last[47:32]);
    assign o_out.current_raw    = signed'(r_last[31:16]);
    assign o_out.spare_word     = r_last[15:0];
    assign o_out.revolutions    = r_o_rev;
    assign o_out.position_count = r_o_pos;
    assign o_out.link_online    = r_online;
    assign o_out.went_offline   = r_o_dropped;

`ifndef SYNTHESIS
    a_offline_clears_wd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_online |-> (r_wd == '0))
        else $error("watchdog not cleared while offline");

    a_drop_means_offline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_dropped) |-> !r_online)
        else $error("timeout result with link still online");

    a_accept_means_online: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_accepted) |-> (r_online && !r_o_dropped))
        else $error("accepted frame without online link");

    a_encoder_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && frame_ok) |=> (r_prev_enc == $past(r_s1_payload[63:48])))
        else $error("previous encoder not updated by accepted frame");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!s1_adv && $past(i_rst_n)) |=> ($stable(r_rev) && $stable(r_wd)))
        else $error("running state moved without a request");
`endif

endmodule
